>>> rtl/spa_pkg.sv
// ----------------------------------------------------------------------------
// spa_pkg
// shared types, widths and codes of the segment pool allocator
// ----------------------------------------------------------------------------
package spa_pkg;

  localparam int MAX_SEG  = 64;
  localparam int IDX_W    = $clog2(MAX_SEG);
  localparam int CNT_W    = $clog2(MAX_SEG + 1);
  localparam int ADDR_W   = 16;
  localparam int LEN_W    = ADDR_W + 1;
  localparam int POOL_MAX = 1 << ADDR_W;
  localparam int PADDR_W  = 3;

  // operations
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_UNDEF = 2'd3;  // behaves as a query

  // result status
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  // fit strategies
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;
  localparam logic [1:0] FIT_NEXT  = 2'd3;

  // register indexes
  localparam logic REG_FIT  = 1'b0;
  localparam logic REG_POOL = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  len;
    logic              used;
  } entry_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [16:0] req_size;
    logic [15:0] address;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] block_offset;
    logic [16:0] free_bytes;
    logic [6:0]  hole_count;
    logic [16:0] largest_hole;
    logic [6:0]  small_hole_count;
    logic        probe_allocated;
  } out_word_t;

  typedef struct packed {
    logic [1:0]       fit_strategy;
    logic [LEN_W-1:0] pool_size;
    logic             pool_wr;
    logic [LEN_W-1:0] pool_new;
  } cfg_t;

  // cursor after removing entry k from a table of cnt entries
  function automatic logic [IDX_W-1:0] drop_cursor(input logic [IDX_W-1:0] cur,
                                                   input logic [CNT_W-1:0] k,
                                                   input logic [CNT_W-1:0] cnt);
    logic [IDX_W-1:0] c;
    c = cur;
    if ({1'b0, c} >= k && c != '0) begin
      c = c - IDX_W'(1);
    end
    if ({1'b0, c} >= cnt - CNT_W'(1)) begin
      c = '0;
    end
    return c;
  endfunction

endpackage

>>> rtl/spa_regs.sv
// ----------------------------------------------------------------------------
// spa_regs
// configuration registers behind the apb-style port
// ----------------------------------------------------------------------------
module spa_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [spa_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output spa_pkg::cfg_t               cfg
);

  logic                        wr;
  logic [1:0]                  fit_strategy;
  logic [spa_pkg::LEN_W-1:0]   pool_size;
  logic [spa_pkg::LEN_W-1:0]   raw;
  logic [spa_pkg::LEN_W-1:0]   pool_new;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign raw    = pwdata[spa_pkg::LEN_W-1:0];

  // clamp into 1 .. pool max
  always_comb begin
    if (raw == '0) begin
      pool_new = spa_pkg::LEN_W'(1);
    end else if (raw > spa_pkg::LEN_W'(spa_pkg::POOL_MAX)) begin
      pool_new = spa_pkg::LEN_W'(spa_pkg::POOL_MAX);
    end else begin
      pool_new = raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_strategy <= spa_pkg::FIT_FIRST;
      pool_size    <= spa_pkg::LEN_W'(spa_pkg::POOL_MAX);
    end else if (wr) begin
      unique case (paddr[2])
        spa_pkg::REG_FIT:  fit_strategy <= pwdata[1:0];
        spa_pkg::REG_POOL: pool_size    <= pool_new;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      spa_pkg::REG_FIT:  prdata = {30'd0, fit_strategy};
      spa_pkg::REG_POOL: prdata = {{(32 - spa_pkg::LEN_W){1'b0}}, pool_size};
      default:           prdata = '0;
    endcase
  end

  assign cfg.fit_strategy = fit_strategy;
  assign cfg.pool_size    = pool_size;
  assign cfg.pool_wr      = wr && (paddr[2] == spa_pkg::REG_POOL);
  assign cfg.pool_new     = pool_new;

endmodule

>>> rtl/segment_pool_allocator.sv
// ----------------------------------------------------------------------------
// segment_pool_allocator
// variable partition allocator with first, best, worst and next fit
// ----------------------------------------------------------------------------
// The segment table (start, length, used) lives in one synchronous memory
// with a registered read; a sequencer walks it. Every word takes one pass
// over the n live segments to pick or find an entry, an optional shift of
// the entries above the split or merge point, a write-back, and a second
// pass that gathers free bytes, hole count and largest hole, with n at most
// 64. A word is accepted only while the sequencer is idle; a finished
// result waits in the output register while the next word is taken.
// Writing pool_size rewrites entry 0 at once and resets the table; after
// reset the init state writes entry 0.
// ----------------------------------------------------------------------------
module segment_pool_allocator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  spa_pkg::in_word_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output spa_pkg::out_word_t          out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [spa_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int IW = spa_pkg::IDX_W;
  localparam int CW = spa_pkg::CNT_W;
  localparam int LW = spa_pkg::LEN_W;

  // sequencer states
  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_DECIDE = 4'd3;
  localparam logic [3:0] S_SHUP   = 4'd4;
  localparam logic [3:0] S_SHDN   = 4'd5;
  localparam logic [3:0] S_WR1    = 4'd6;
  localparam logic [3:0] S_WR2    = 4'd7;
  localparam logic [3:0] S_STAT   = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  spa_pkg::cfg_t cfg;

  spa_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // segment table memory
  spa_pkg::entry_t mem [spa_pkg::MAX_SEG];
  spa_pkg::entry_t rdata;
  logic            we;
  logic [IW-1:0]   wa;
  spa_pkg::entry_t wd;
  logic [IW-1:0]   ra;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata <= mem[ra];
  end

  // control state
  logic [3:0]    state;
  logic [CW-1:0] count;
  logic [IW-1:0] cursor;
  logic [CW-1:0] ic;        // read issue pointer
  logic          rd_vld;
  logic [IW-1:0] rd_idx;
  logic          issue;

  // captured word
  logic [1:0]        op;
  logic [LW-1:0]     req;
  logic [15:0]       addr;

  // scan results
  logic              sel_found;
  logic [IW-1:0]     sel_idx;
  spa_pkg::entry_t   sel_e;
  logic              alt_found;   // first fit overall, next-fit wrap
  logic [IW-1:0]     alt_idx;
  spa_pkg::entry_t   alt_e;
  logic              hit_found;
  logic [IW-1:0]     hit_idx;
  spa_pkg::entry_t   hit_e;
  spa_pkg::entry_t   hit_prev;
  logic              next_ok;
  spa_pkg::entry_t   next_e;
  spa_pkg::entry_t   prev_e;
  logic [6:0]        small_cnt;
  logic              owner_used;

  // chosen segment for split
  logic [IW-1:0]     s_idx;
  spa_pkg::entry_t   s_e;
  logic [1:0]        drop_d;

  // stats pass
  logic [LW-1:0]     fbytes;
  logic [6:0]        holes;
  logic [LW-1:0]     largest;
  logic [1:0]        status;
  logic [15:0]       offset;

  // decide logic
  logic              ch_found;
  logic [IW-1:0]     ch_idx;
  spa_pkg::entry_t   ch_e;
  logic              fit_ok;
  logic              need_split;
  logic              pf;
  logic              nf;
  logic [IW-1:0]     mg_wa;
  spa_pkg::entry_t   mg_wd;
  logic [CW-1:0]     mg_base;
  logic [1:0]        mg_d;
  logic [IW-1:0]     mg_cursor;
  logic [CW-1:0]     k_ext;

  spa_pkg::entry_t   cur_e;
  logic              fits;

  assign in_stall = (state != S_IDLE);
  assign cur_e    = rdata;
  assign fits     = !cur_e.used && (cur_e.len >= req);

  always_comb begin
    // next fit wraps to the first fit overall
    if (cfg.fit_strategy == spa_pkg::FIT_NEXT && !sel_found) begin
      ch_found = alt_found;
      ch_idx   = alt_idx;
      ch_e     = alt_e;
    end else begin
      ch_found = sel_found;
      ch_idx   = sel_idx;
      ch_e     = sel_e;
    end
    fit_ok     = ch_found && (req != '0) && (ch_e.len >= req);
    need_split = ch_e.len > req;

    // merge plan for a free
    k_ext = {1'b0, hit_idx};
    pf    = hit_found && (hit_idx != '0) && !hit_prev.used;
    nf    = next_ok && !next_e.used;
    mg_wd = hit_e;
    mg_wd.used = 1'b0;
    mg_wa   = hit_idx;
    mg_base = k_ext;
    mg_d    = 2'd0;
    mg_cursor = cursor;
    if (pf && nf) begin
      mg_wa      = hit_idx - IW'(1);
      mg_wd      = hit_prev;
      mg_wd.len  = hit_prev.len + hit_e.len + next_e.len;
      mg_d       = 2'd2;
      mg_cursor  = spa_pkg::drop_cursor(
                     spa_pkg::drop_cursor(cursor, k_ext, count), k_ext, count - CW'(1));
    end else if (pf) begin
      mg_wa      = hit_idx - IW'(1);
      mg_wd      = hit_prev;
      mg_wd.len  = hit_prev.len + hit_e.len;
      mg_d       = 2'd1;
      mg_cursor  = spa_pkg::drop_cursor(cursor, k_ext, count);
    end else if (nf) begin
      mg_wd.len  = hit_e.len + next_e.len;
      mg_base    = k_ext + CW'(1);
      mg_d       = 2'd1;
      mg_cursor  = spa_pkg::drop_cursor(cursor, k_ext + CW'(1), count);
    end
  end

  // read issue
  always_comb begin
    case (state)
      S_SCAN, S_STAT, S_SHDN: issue = (ic < count);
      S_SHUP:                 issue = (ic > {1'b0, s_idx});
      default:                issue = 1'b0;
    endcase
    ra = ic[IW-1:0];
  end

  // memory write port
  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = '0;
    if (cfg.pool_wr) begin
      // table reset to one free segment
      we     = 1'b1;
      wd.len = cfg.pool_new;
    end else begin
      case (state)
        S_INIT: begin
          we     = 1'b1;
          wd.len = cfg.pool_size;
        end
        S_DECIDE: begin
          if (op == spa_pkg::OP_ALLOC && fit_ok && !need_split) begin
            we      = 1'b1;
            wa      = ch_idx;
            wd      = ch_e;
            wd.used = 1'b1;
          end else if (op == spa_pkg::OP_FREE && hit_found) begin
            we = 1'b1;
            wa = mg_wa;
            wd = mg_wd;
          end
        end
        S_SHUP: begin
          we = rd_vld;
          wa = rd_idx + IW'(1);
          wd = rdata;
        end
        S_SHDN: begin
          we = rd_vld;
          wa = rd_idx - IW'(drop_d);
          wd = rdata;
        end
        S_WR1: begin
          // split-off remainder
          we       = 1'b1;
          wa       = s_idx + IW'(1);
          wd.start = s_e.start + req[15:0];
          wd.len   = s_e.len - req;
          wd.used  = 1'b0;
        end
        S_WR2: begin
          we       = 1'b1;
          wa       = s_idx;
          wd.start = s_e.start;
          wd.len   = req;
          wd.used  = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      count     <= CW'(1);
      cursor    <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
      ic        <= '0;
    end else begin
      rd_vld <= issue;
      rd_idx <= ic[IW-1:0];
      if (issue) begin
        ic <= (state == S_SHUP) ? ic - CW'(1) : ic + CW'(1);
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg.pool_wr) begin
        count  <= CW'(1);
        cursor <= '0;
      end

      unique case (state)
        S_INIT: state <= S_IDLE;

        S_IDLE: begin
          if (in_valid) begin
            op         <= in_data.operation;
            req        <= in_data.req_size;
            addr       <= in_data.address;
            sel_found  <= 1'b0;
            alt_found  <= 1'b0;
            hit_found  <= 1'b0;
            next_ok    <= 1'b0;
            small_cnt  <= '0;
            owner_used <= 1'b0;
            status     <= spa_pkg::ST_OK;
            offset     <= '0;
            ic         <= '0;
            state      <= S_SCAN;
          end
        end

        S_SCAN: begin
          if (rd_vld) begin
            prev_e <= cur_e;
            // fit selection per strategy, lowest address wins ties
            case (cfg.fit_strategy)
              spa_pkg::FIT_FIRST: begin
                if (fits && !sel_found) begin
                  sel_found <= 1'b1; sel_idx <= rd_idx; sel_e <= cur_e;
                end
              end
              spa_pkg::FIT_BEST: begin
                if (fits && (!sel_found || cur_e.len < sel_e.len)) begin
                  sel_found <= 1'b1; sel_idx <= rd_idx; sel_e <= cur_e;
                end
              end
              spa_pkg::FIT_WORST: begin
                if (!cur_e.used && (!sel_found || cur_e.len > sel_e.len)) begin
                  sel_found <= 1'b1; sel_idx <= rd_idx; sel_e <= cur_e;
                end
              end
              default: begin
                if (fits && !sel_found && rd_idx >= cursor) begin
                  sel_found <= 1'b1; sel_idx <= rd_idx; sel_e <= cur_e;
                end
              end
            endcase
            if (fits && !alt_found) begin
              alt_found <= 1'b1; alt_idx <= rd_idx; alt_e <= cur_e;
            end
            // free lookup and its neighbors
            if (cur_e.used && cur_e.start == addr && !hit_found) begin
              hit_found <= 1'b1;
              hit_idx   <= rd_idx;
              hit_e     <= cur_e;
              hit_prev  <= prev_e;
            end
            if (hit_found && rd_idx == hit_idx + IW'(1)) begin
              next_ok <= 1'b1;
              next_e  <= cur_e;
            end
            // query statistics
            if (!cur_e.used && cur_e.len <= req) begin
              small_cnt <= small_cnt + 7'd1;
            end
            if (cur_e.start <= addr) begin
              owner_used <= cur_e.used;
            end
          end
          if (!issue && !rd_vld) begin
            state <= S_DECIDE;
          end
        end

        S_DECIDE: begin
          fbytes  <= '0;
          holes   <= '0;
          largest <= '0;
          state   <= S_STAT;
          ic      <= '0;
          if (op == spa_pkg::OP_ALLOC) begin
            if (!fit_ok) begin
              status <= spa_pkg::ST_NOFIT;
            end else if (need_split) begin
              if (count >= CW'(spa_pkg::MAX_SEG)) begin
                status <= spa_pkg::ST_FULL;
              end else begin
                s_idx  <= ch_idx;
                s_e    <= ch_e;
                offset <= ch_e.start;
                ic     <= count - CW'(1);
                state  <= S_SHUP;
              end
            end else begin
              offset <= ch_e.start;
              cursor <= ({1'b0, ch_idx} + CW'(1) < count) ? ch_idx + IW'(1) : '0;
            end
          end else if (op == spa_pkg::OP_FREE) begin
            if (!hit_found) begin
              status <= spa_pkg::ST_UNKNOWN;
            end else if (mg_d != 2'd0) begin
              drop_d <= mg_d;
              cursor <= mg_cursor;
              ic     <= mg_base + CW'(mg_d);
              state  <= S_SHDN;
            end
          end
        end

        S_SHUP: begin
          if (!issue && !rd_vld) begin
            state <= S_WR1;
          end
        end

        S_SHDN: begin
          if (!issue && !rd_vld) begin
            count <= count - CW'(drop_d);
            ic    <= '0;
            state <= S_STAT;
          end
        end

        S_WR1: state <= S_WR2;

        S_WR2: begin
          // cursor moves to the remainder together with the grown count
          count  <= count + CW'(1);
          cursor <= s_idx + IW'(1);
          ic     <= '0;
          state  <= S_STAT;
        end

        S_STAT: begin
          if (rd_vld && !cur_e.used) begin
            fbytes <= fbytes + cur_e.len;
            holes  <= holes + 7'd1;
            if (cur_e.len > largest) begin
              largest <= cur_e.len;
            end
          end
          if (!issue && !rd_vld) begin
            state <= S_DONE;
          end
        end

        S_DONE: begin
          // hand over once the output register is free
          if (!out_valid || !out_stall) begin
            out_valid                 <= 1'b1;
            out_data.status           <= status;
            out_data.block_offset     <= offset;
            out_data.free_bytes       <= fbytes;
            out_data.hole_count       <= holes;
            out_data.largest_hole     <= largest;
            out_data.small_hole_count <=
              (op == spa_pkg::OP_ALLOC || op == spa_pkg::OP_FREE) ? 7'd0 : small_cnt;
            out_data.probe_allocated  <=
              (op == spa_pkg::OP_ALLOC || op == spa_pkg::OP_FREE) ? 1'b0 : owner_used;
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // table never empty and never past its capacity
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != '0 && count <= CW'(spa_pkg::MAX_SEG))
    else $error("segment count out of range");

  // next-fit cursor always points at a live entry
  a_cursor_live: assert property (@(posedge clk) disable iff (rst)
    {1'b0, cursor} < count)
    else $error("fit cursor past table end");

  // reported free space never exceeds the pool
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.free_bytes <= cfg.pool_size)
    else $error("free bytes exceed pool size");
`endif

endmodule

>>> bench/segment_pool_allocator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// segment_pool_allocator_tb
// self-checking bench for the segment pool allocator: a behavioral segment
// table predicts every result word, which is compared as a whole word with
// the block's output under random input gaps and output stalls
// ----------------------------------------------------------------------------
module segment_pool_allocator_tb;

  localparam int N_RANDOM    = 800;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_WAIT  = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // block ports
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  spa_pkg::in_word_t    in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  spa_pkg::out_word_t   out_data;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [spa_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  segment_pool_allocator u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // behavioral segment table
  // ---------------------------------------------------------------------
  logic [15:0] tbl_start [spa_pkg::MAX_SEG];
  logic [16:0] tbl_len   [spa_pkg::MAX_SEG];
  logic        tbl_used  [spa_pkg::MAX_SEG];
  int          tbl_count;
  int          cursor;
  logic [1:0]  fit_mode;
  logic [16:0] pool_bytes;

  spa_pkg::out_word_t expected_words[$];
  spa_pkg::in_word_t  pending_words[$];
  logic [15:0] live_blocks[$];  // offsets for free stimulus: random seeds, then the allocated starts

  int n_mismatch = 0;
  int n_checked  = 0;
  int n_sent     = 0;
  int n_alloc_ok = 0;
  int n_full     = 0;
  int n_unknown  = 0;
  longint cycles = 0;

  function automatic void table_reset();
    for (int i = 0; i < spa_pkg::MAX_SEG; i++) begin
      tbl_start[i] = '0;
      tbl_len[i]   = '0;
      tbl_used[i]  = 1'b0;
    end
    tbl_len[0] = pool_bytes;
    tbl_count  = 1;
    cursor     = 0;
  endfunction

  function automatic void remove_entry(int k);
    for (int j = k; j + 1 < tbl_count; j++) begin
      tbl_start[j] = tbl_start[j+1];
      tbl_len[j]   = tbl_len[j+1];
      tbl_used[j]  = tbl_used[j+1];
    end
    tbl_count--;
    if (cursor >= k && cursor > 0) cursor--;
    if (cursor >= tbl_count) cursor = 0;
  endfunction

  function automatic int choose_hole(logic [16:0] req);
    int sel;
    int i;
    sel = -1;
    case (fit_mode)
      spa_pkg::FIT_FIRST: begin
        for (i = 0; i < tbl_count; i++)
          if (!tbl_used[i] && tbl_len[i] >= req) begin
            sel = i;
            break;
          end
      end
      spa_pkg::FIT_BEST: begin
        for (i = 0; i < tbl_count; i++)
          if (!tbl_used[i] && tbl_len[i] >= req && (sel < 0 || tbl_len[i] < tbl_len[sel]))
            sel = i;
      end
      spa_pkg::FIT_WORST: begin
        for (i = 0; i < tbl_count; i++)
          if (!tbl_used[i] && (sel < 0 || tbl_len[i] > tbl_len[sel]))
            sel = i;
        if (sel >= 0 && tbl_len[sel] < req) sel = -1;
      end
      default: begin
        if (cursor >= tbl_count) cursor = 0;
        for (int n = 0; n < tbl_count; n++) begin
          i = (cursor + n) % tbl_count;
          if (!tbl_used[i] && tbl_len[i] >= req) begin
            sel = i;
            break;
          end
        end
      end
    endcase
    return sel;
  endfunction

  // predicts the result word of one input word and updates the table
  function automatic spa_pkg::out_word_t allocator_step(spa_pkg::in_word_t w);
    spa_pkg::out_word_t r;
    int sel;
    int k;
    int owner;
    logic [16:0] biggest;
    r = '0;
    if (w.operation == spa_pkg::OP_ALLOC) begin
      sel = (w.req_size == 0) ? -1 : choose_hole(w.req_size);
      if (sel < 0) begin
        r.status = spa_pkg::ST_NOFIT;
      end else if (tbl_len[sel] > w.req_size) begin
        if (tbl_count >= spa_pkg::MAX_SEG) begin
          r.status = spa_pkg::ST_FULL;
        end else begin
          for (int j = tbl_count; j > sel + 1; j--) begin
            tbl_start[j] = tbl_start[j-1];
            tbl_len[j]   = tbl_len[j-1];
            tbl_used[j]  = tbl_used[j-1];
          end
          tbl_count++;
          tbl_start[sel+1] = tbl_start[sel] + w.req_size[15:0];
          tbl_len[sel+1]   = tbl_len[sel] - w.req_size;
          tbl_used[sel+1]  = 1'b0;
          tbl_len[sel]     = w.req_size;
          tbl_used[sel]    = 1'b1;
          cursor = sel + 1;
          r.block_offset = tbl_start[sel];
        end
      end else begin
        tbl_used[sel] = 1'b1;
        cursor = (sel + 1 < tbl_count) ? sel + 1 : 0;
        r.block_offset = tbl_start[sel];
      end
    end else if (w.operation == spa_pkg::OP_FREE) begin
      k = -1;
      for (int i = 0; i < tbl_count; i++)
        if (tbl_used[i] && tbl_start[i] == w.address) begin
          k = i;
          break;
        end
      if (k < 0) begin
        r.status = spa_pkg::ST_UNKNOWN;
      end else begin
        tbl_used[k] = 1'b0;
        if (k > 0 && !tbl_used[k-1]) begin
          tbl_len[k-1] += tbl_len[k];
          remove_entry(k);
          k--;
        end
        if (k + 1 < tbl_count && !tbl_used[k+1]) begin
          tbl_len[k] += tbl_len[k+1];
          remove_entry(k + 1);
        end
      end
    end else begin
      // query, and the undefined operation code behaves the same
      owner = 0;
      for (int i = 0; i < tbl_count; i++) begin
        if (!tbl_used[i] && tbl_len[i] <= w.req_size) r.small_hole_count++;
        if (tbl_start[i] <= w.address) owner = i;
      end
      r.probe_allocated = tbl_used[owner];
    end
    biggest = '0;
    for (int i = 0; i < tbl_count; i++)
      if (!tbl_used[i]) begin
        r.free_bytes += tbl_len[i];
        r.hole_count++;
        if (tbl_len[i] > biggest) biggest = tbl_len[i];
      end
    r.largest_hole = biggest;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // driver: bursts of words with random gaps
  // ---------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;
  logic driving_on = 1'b0;  // set by the initial block per phase

  always @(posedge clk) begin
    if (!rst) begin
      cycles <= cycles + 1;
      // word accepted at this edge
      if (in_valid && !in_stall) begin
        expected_words.push_back(allocator_step(in_data));
        n_sent <= n_sent + 1;
      end
      if (!in_valid || !in_stall) begin
        // free to present a new word or go idle
        if (driving_on && pending_words.size() > 0 && gap_left == 0) begin
          in_valid <= 1'b1;
          in_data  <= pending_words.pop_front();
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            // end of burst: pick a gap, often none
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left <= $urandom_range(0, 20);
          end
        end else begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // monitor: compares each result word with the oldest prediction
  // ---------------------------------------------------------------------
  int stall_phase = 0;

  always @(posedge clk) begin
    if (!rst) begin
      // own stall pattern: quiet stretches alternate with busy ones
      stall_phase <= (stall_phase + 1) % 400;
      out_stall   <= (stall_phase < 150) ? 1'b0 : ($urandom_range(0, 2) == 0);
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          n_mismatch <= n_mismatch + 1;
          if (n_mismatch < 10) $display("unexpected result word %p", out_data);
        end else begin
          spa_pkg::out_word_t e;
          e = expected_words.pop_front();
          n_checked <= n_checked + 1;
          if (e.status == spa_pkg::ST_FULL) n_full <= n_full + 1;
          if (e.status == spa_pkg::ST_UNKNOWN) n_unknown <= n_unknown + 1;
          if (out_data !== e) begin
            n_mismatch <= n_mismatch + 1;
            if (n_mismatch < 10)
              $display("mismatch: expected %p actual %p", e, out_data);
          end else if (e.status == spa_pkg::ST_OK && e.block_offset != 0) begin
            n_alloc_ok <= n_alloc_ok + 1;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------
  task automatic reg_write(logic [spa_pkg::PADDR_W-1:0] a, logic [31:0] d);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic set_fit(logic [1:0] m);
    reg_write(spa_pkg::PADDR_W'(spa_pkg::REG_FIT) << 2, {30'd0, m});
    fit_mode = m;
  endtask

  task automatic set_pool(logic [16:0] v);
    reg_write(spa_pkg::PADDR_W'(spa_pkg::REG_POOL) << 2, {15'd0, v});
    pool_bytes = (v == 0) ? 17'd1 :
                 (v > spa_pkg::POOL_MAX ? 17'(spa_pkg::POOL_MAX) : v);
    table_reset();
  endtask

  function automatic spa_pkg::in_word_t make_word(logic [1:0] op, logic [16:0] sz,
                                                  logic [15:0] ad);
    spa_pkg::in_word_t w;
    w.operation = op;
    w.req_size  = sz;
    w.address   = ad;
    return w;
  endfunction

  // runs the queued words and waits until every result has arrived
  task automatic run_phase();
    driving_on = 1'b1;
    wait (pending_words.size() == 0 && !in_valid);
    wait (expected_words.size() == 0);
    driving_on = 1'b0;
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // random phase: mostly sensible allocs and frees of live blocks
  task automatic queue_random(int count, logic [16:0] pool);
    logic [16:0] sz;
    logic [15:0] ad;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        // mostly small sizes so the table fills up; sometimes huge
        case ($urandom_range(0, 9))
          0:       sz = 17'($urandom_range(0, 131071));
          1:       sz = pool;
          default: sz = 17'($urandom_range(1, (pool > 64) ? pool / 32 : pool));
        endcase
        pending_words.push_back(make_word(spa_pkg::OP_ALLOC, sz, 16'($urandom)));
      end else if (pick < 80) begin
        // free an offset seen before, or a random one
        if (live_blocks.size() > 0 && $urandom_range(0, 4) != 0) begin
          int j;
          j  = $urandom_range(0, live_blocks.size() - 1);
          ad = live_blocks[j];
          live_blocks.delete(j);
        end else begin
          ad = 16'($urandom);
        end
        pending_words.push_back(make_word(spa_pkg::OP_FREE,
                                          17'($urandom_range(0, 131071)), ad));
      end else begin
        pending_words.push_back(make_word(
          $urandom_range(0, 1) ? spa_pkg::OP_QUERY : spa_pkg::OP_UNDEF,
          17'($urandom_range(0, 131071)), 16'($urandom)));
      end
    end
  endtask

  // candidate free offsets: random offsets anywhere in the pool
  task automatic seed_offsets(logic [16:0] pool);
    live_blocks.delete();
    for (int i = 0; i < 200; i++)
      live_blocks.push_back(16'($urandom_range(0, pool - 1) & ~16'h0));
  endtask

  initial begin
    fit_mode   = spa_pkg::FIT_FIRST;
    pool_bytes = 17'(spa_pkg::POOL_MAX);
    table_reset();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // directed: default pool, first fit, extremes and special cases
    pending_words.push_back(make_word(spa_pkg::OP_QUERY, 17'h1FFFF, 16'hFFFF));
    pending_words.push_back(make_word(spa_pkg::OP_ALLOC, 17'd0, 16'd0));      // zero size
    pending_words.push_back(make_word(spa_pkg::OP_ALLOC, 17'd65537, 16'd0));  // too big
    pending_words.push_back(make_word(spa_pkg::OP_ALLOC, 17'd1, 16'd0));
    pending_words.push_back(make_word(spa_pkg::OP_ALLOC, 17'd100, 16'd0));
    pending_words.push_back(make_word(spa_pkg::OP_ALLOC, 17'd1000, 16'd0));
    pending_words.push_back(make_word(spa_pkg::OP_FREE, 17'd0, 16'd1));       // merge later
    pending_words.push_back(make_word(spa_pkg::OP_FREE, 17'd0, 16'd1));       // already free
    pending_words.push_back(make_word(spa_pkg::OP_FREE, 17'd0, 16'h5555));    // unknown
    pending_words.push_back(make_word(spa_pkg::OP_QUERY, 17'd100, 16'd0));
    pending_words.push_back(make_word(spa_pkg::OP_UNDEF, 17'd0, 16'd101));    // undefined op
    pending_words.push_back(make_word(spa_pkg::OP_FREE, 17'd0, 16'd0));
    pending_words.push_back(make_word(spa_pkg::OP_FREE, 17'd0, 16'd101));
    pending_words.push_back(make_word(spa_pkg::OP_ALLOC, 17'd65536, 16'd0));  // whole pool
    pending_words.push_back(make_word(spa_pkg::OP_ALLOC, 17'd1, 16'd0));      // nothing left
    pending_words.push_back(make_word(spa_pkg::OP_QUERY, 17'd0, 16'hFFFF));
    pending_words.push_back(make_word(spa_pkg::OP_FREE, 17'd0, 16'd0));
    run_phase();

    // tiny pool, written as zero, then a 64-entry fill for table full
    set_pool(17'd0);
    pending_words.push_back(make_word(spa_pkg::OP_ALLOC, 17'd1, 16'd0));
    pending_words.push_back(make_word(spa_pkg::OP_QUERY, 17'd1, 16'd5));      // beyond pool end
    run_phase();
    set_pool(17'd100);
    for (int i = 0; i < 66; i++)
      pending_words.push_back(make_word(spa_pkg::OP_ALLOC, 17'd1, 16'd0));
    pending_words.push_back(make_word(spa_pkg::OP_ALLOC, 17'd37, 16'd0));     // exact fit when full
    pending_words.push_back(make_word(spa_pkg::OP_QUERY, 17'd1, 16'd70));
    run_phase();
    set_pool(17'h1FFFF);  // saturates to full pool
    run_phase();

    // random phases across strategies and pool sizes
    for (int ph = 0; ph < 8; ph++) begin
      logic [16:0] pool;
      case (ph % 4)
        0:       pool = 17'(spa_pkg::POOL_MAX);
        1:       pool = 17'd64;
        default: pool = 17'($urandom_range(1, 65536));
      endcase
      set_fit(2'(ph));
      set_pool(pool);
      seed_offsets(pool);
      // frees of real block starts: derive them as the phase runs
      for (int b = 0; b < N_RANDOM / 8; b += 10) begin
        queue_random(10, pool);
        run_phase();
        live_blocks.delete();
        for (int i = 0; i < tbl_count; i++)
          if (tbl_used[i]) live_blocks.push_back(tbl_start[i]);
      end
    end

    $display("checked %0d result words over %0d inputs, four fit modes, several pools",
             n_checked, n_sent);
    $display("successful allocs %0d, table full %0d, unknown frees %0d",
             n_alloc_ok, n_full, n_unknown);
    if (n_mismatch == 0 && expected_words.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> segment_pool_allocator.f
rtl/spa_pkg.sv
rtl/spa_regs.sv
rtl/segment_pool_allocator.sv
bench/segment_pool_allocator_tb.sv
